// ===== sv/jcdn_pkg.sv =====
// Package for the Julian calendar day number converter.
// Holds calendar constants, reciprocal multipliers and the month offset table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jcdn_pkg;

    // Calendar constants.
    localparam logic [14:0]        EPOCH_OFFSET  = 15'd32083;
    localparam logic [7:0]         DAYS_5_MONTHS = 8'd153;
    localparam logic [10:0]        DAYS_4_YEARS  = 11'd1461;
    localparam logic [12:0]        YEAR_BIAS     = 13'd4800;
    localparam logic [12:0]        YEAR_BIAS_BC  = 13'd4801;
    localparam logic signed [18:0] FIRST_YEAR    = -19'sd4713;

    // Offset added to four times the day number: 4 * 32083 - 1.
    localparam logic [28:0] T_OFFSET = 29'd128331;

    // Reciprocals for the constant divisions. Each is ceil(2^shift / divisor),
    // exact over the full input range of its stage.
    localparam logic [29:0] RECIP_1461    = 30'd752574694;
    localparam int          RECIP_1461_SH = 40;
    localparam logic [11:0] RECIP_153     = 12'd3427;
    localparam int          RECIP_153_SH  = 19;
    localparam logic [8:0]  RECIP_5       = 9'd410;
    localparam int          RECIP_5_SH    = 11;

    // Control bits that travel with each item down the pipeline.
    typedef struct packed {
        logic vld;
        logic cmd;
        logic zero;
    } t_ctl;

    // Days before the start of a March-based month: (idx * 153 + 2) / 5.
    function automatic logic [8:0] mo_off(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/julian_calendar_day_number_convert.sv =====
// Top level of the Julian calendar day number converter, five register stages.
// Each accepted item is registered through stages A, B, C and D and then the output register,
// which shows its result with o_done; throughput is one item per cycle, set by the pipeline.
// busy is always low: the pipeline never stalls and the receiver cannot stall it.
// Reset (i_rst_n low, synchronous) clears the valid bits; data registers keep their values.
// Depends on jcdn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module julian_calendar_day_number_convert
    import jcdn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_command,
    input  wire logic [25:0]        i_day_number_in,
    input  wire logic signed [18:0] i_year_in,
    input  wire logic [3:0]         i_month_in,
    input  wire logic [5:0]         i_day_in,
    output logic                    o_done,
    output logic [26:0]             o_day_number_out,
    output logic signed [18:0]      o_year_out,
    output logic [3:0]              o_month_out,
    output logic [4:0]              o_day_out
);

    // The pipeline is free running, so every start is a transfer.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage A: input decode.
    // The day-to-date path forms t = 4 * dn + 4 * 32083 - 1.
    // The date-to-day path checks the date and moves it to a March-based
    // year counted from 4801 B.C., and looks up the month offset.
    // ------------------------------------------------------------------
    t_ctl        r_a_ctl, n_a_ctl;
    logic [28:0] r_a_t;
    logic        r_a_ok;
    logic [18:0] r_a_yadj;
    logic [8:0]  r_a_mdd;

    logic        w_mon_ok;
    logic        w_day_ok;
    logic        w_first;
    logic        w_early;
    logic [19:0] w_yb;
    logic [3:0]  w_midx;

    always_comb begin
        w_early  = (i_month_in == 4'd1) || (i_month_in == 4'd2);
        w_mon_ok = i_month_in inside {[4'd1:4'd12]};
        w_day_ok = i_day_in inside {[6'd1:6'd31]};
        // The first of January 4713 B.C. is day zero and is refused.
        w_first  = (i_year_in == FIRST_YEAR) && (i_month_in == 4'd1) && (i_day_in == 6'd1);
        // B.C. years have no year zero, so they get one more unit of bias.
        w_yb = {i_year_in[18], i_year_in}
             + (i_year_in[18] ? 20'(YEAR_BIAS_BC) : 20'(YEAR_BIAS))
             - (w_early ? 20'd1 : 20'd0);
        w_midx = w_early ? (i_month_in + 4'd9) : (i_month_in - 4'd3);
        n_a_ctl.vld  = start;
        n_a_ctl.cmd  = i_command;
        n_a_ctl.zero = (i_day_number_in == 26'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl <= n_a_ctl;
        end
        r_a_t    <= 29'({i_day_number_in, 2'b00}) + T_OFFSET;
        r_a_ok   <= (i_year_in != 19'sd0) && (i_year_in >= FIRST_YEAR)
                    && w_mon_ok && w_day_ok && !w_first;
        r_a_yadj <= w_yb[18:0];
        r_a_mdd  <= mo_off(w_midx) + 9'(i_day_in);
    end

    // ------------------------------------------------------------------
    // Stage B: the two wide multiplications.
    // Day path: q = t / 1461 through the reciprocal, which gives the
    // March-based year counted from 4801 B.C.
    // Date path: year * 1461, the days in whole years.
    // ------------------------------------------------------------------
    t_ctl        r_b_ctl;
    logic [28:0] r_b_t;
    logic [17:0] r_b_q;
    logic        r_b_ok;
    logic [29:0] r_b_yprod;
    logic [8:0]  r_b_mdd;
    logic [58:0] w_prod1;

    assign w_prod1 = 59'(r_a_t) * 59'(RECIP_1461);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else begin
            r_b_ctl <= r_a_ctl;
        end
        r_b_t     <= r_a_t;
        r_b_q     <= w_prod1[RECIP_1461_SH +: 18];
        r_b_ok    <= r_a_ok;
        r_b_yprod <= 30'(r_a_yadj) * 30'(DAYS_4_YEARS);
        r_b_mdd   <= r_a_mdd;
    end

    // ------------------------------------------------------------------
    // Stage C: day of the March-based year, and the finished day number.
    // Day path: doy = (t mod 1461) / 4 + 1, then t2 = 5 * doy - 3.
    // Date path: year * 1461 / 4 + month offset + day - 32083. For every
    // accepted date this is at least zero, so no clamp is needed.
    // ------------------------------------------------------------------
    t_ctl        r_c_ctl;
    logic [10:0] r_c_t2;
    logic [17:0] r_c_q;
    logic [26:0] r_c_dn;
    logic [28:0] w_rem;
    logic [8:0]  w_doy;
    logic [27:0] w_dn;

    always_comb begin
        w_rem = r_b_t - 29'(r_b_q) * 29'(DAYS_4_YEARS);
        w_doy = w_rem[10:2] + 9'd1;
        w_dn  = r_b_yprod[29:2] + 28'(r_b_mdd) - 28'(EPOCH_OFFSET);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else begin
            r_c_ctl <= r_b_ctl;
        end
        r_c_t2 <= 11'(w_doy) * 11'd5 - 11'd3;
        r_c_q  <= r_b_q;
        r_c_dn <= r_b_ok ? w_dn[26:0] : 27'd0;
    end

    // ------------------------------------------------------------------
    // Stage D: March-based month index = t2 / 153 through the reciprocal.
    // ------------------------------------------------------------------
    t_ctl        r_d_ctl;
    logic [10:0] r_d_t2;
    logic [17:0] r_d_q;
    logic [26:0] r_d_dn;
    logic [3:0]  r_d_m0;
    logic [22:0] w_prod2;

    assign w_prod2 = 23'(r_c_t2) * 23'(RECIP_153);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else begin
            r_d_ctl <= r_c_ctl;
        end
        r_d_t2 <= r_c_t2;
        r_d_q  <= r_c_q;
        r_d_dn <= r_c_dn;
        r_d_m0 <= w_prod2[RECIP_153_SH +: 4];
    end

    // ------------------------------------------------------------------
    // Stage E: day of month, January-based month and year, output register.
    // day = (t2 mod 153) / 5 + 1. Months 10 and 11 of the March year are
    // January and February of the next calendar year. Years at or below
    // zero step back one, since there is no year zero.
    // ------------------------------------------------------------------
    logic        r_done;
    logic [26:0] r_day_number_out;
    logic [18:0] r_year_out;
    logic [3:0]  r_month_out;
    logic [4:0]  r_day_out;

    logic [10:0]        w_r2;
    logic [15:0]        w_prod3;
    logic [4:0]         w_day;
    logic               w_wrap;
    logic [3:0]         w_mon;
    logic signed [19:0] w_y1;
    logic signed [19:0] w_y2;
    logic               w_date;

    always_comb begin
        w_r2    = r_d_t2 - 11'(r_d_m0) * 11'(DAYS_5_MONTHS);
        w_prod3 = 16'(w_r2[7:0]) * 16'(RECIP_5);
        w_day   = w_prod3[RECIP_5_SH +: 5] + 5'd1;
        w_wrap  = (r_d_m0 >= 4'd10);
        w_mon   = w_wrap ? (r_d_m0 - 4'd9) : (r_d_m0 + 4'd3);
        w_y1    = $signed(20'(r_d_q)) + (w_wrap ? 20'sd1 : 20'sd0) - $signed(20'(YEAR_BIAS));
        w_y2    = (w_y1 <= 20'sd0) ? (w_y1 - 20'sd1) : w_y1;
        // A date comes out only for the day-to-date command with a day number above zero.
        w_date  = !r_d_ctl.cmd && !r_d_ctl.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_d_ctl.vld;
        end
        r_day_number_out <= r_d_ctl.cmd ? r_d_dn : 27'd0;
        r_year_out       <= w_date ? w_y2[18:0] : 19'd0;
        r_month_out      <= w_date ? w_mon : 4'd0;
        r_day_out        <= w_date ? w_day : 5'd0;
    end

    assign o_done           = r_done;
    assign o_day_number_out = r_day_number_out;
    assign o_year_out       = $signed(r_year_out);
    assign o_month_out      = r_month_out;
    assign o_day_out        = r_day_out;

endmodule

`default_nettype wire

// ===== sv/jcdn_checker.sv =====
// Port-level checker for the Julian calendar day number converter, with its bind.
// Depends on julian_calendar_day_number_convert.
`timescale 1ns / 1ps
`default_nettype none

module jcdn_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_done,
    input wire logic [26:0]        o_day_number_out,
    input wire logic signed [18:0] o_year_out,
    input wire logic [3:0]         o_month_out,
    input wire logic [4:0]         o_day_out
);

    // Every transfer yields exactly one result on o_done.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_done)
        else $error("result missing after a transfer");

    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##5 !o_done)
        else $error("result without a transfer");

    // A day number result leaves the date fields clear.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_day_number_out != 27'd0)) |->
        ((o_year_out == 19'sd0) && (o_month_out == 4'd0) && (o_day_out == 5'd0)))
        else $error("both directions show a result");

    // A produced date is a well formed calendar date with no year zero.
    a_date_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_month_out != 4'd0)) |->
        ((o_month_out <= 4'd12) && (o_day_out != 5'd0) && (o_year_out != 19'sd0)))
        else $error("malformed date");

endmodule

bind julian_calendar_day_number_convert jcdn_checker u_jcdn_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_day_number_out (o_day_number_out),
    .o_year_out       (o_year_out),
    .o_month_out      (o_month_out),
    .o_day_out        (o_day_out)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for julian_calendar_day_number_convert, both conversion directions.
// A directed table and a random phase are scored against an in-bench calendar predictor.
// Depends on jcdn_pkg and the converter RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import jcdn_pkg::*;

    // Direction codes carried on i_command.
    localparam logic CMD_TO_DATE = 1'b0;
    localparam logic CMD_TO_DAY  = 1'b1;

    // Calendar constants widened once so that the predictor does all of its
    // arithmetic in signed 64-bit integers, like plain integer math.
    localparam longint L_EPOCH   = longint'(EPOCH_OFFSET);
    localparam longint L_5MONTHS = longint'(DAYS_5_MONTHS);
    localparam longint L_4YEARS  = longint'(DAYS_4_YEARS);
    localparam longint L_BIAS    = longint'(YEAR_BIAS);
    localparam longint L_BIAS_BC = longint'(YEAR_BIAS_BC);
    localparam longint L_FIRST   = longint'(FIRST_YEAR);

    localparam int RANDOM_ITEMS = 750;
    localparam int SETTLE       = 12;      // comfortably above the pipeline depth
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_CAP    = 40;

    // One converter result, laid out like the output ports.
    typedef struct packed {
        logic [26:0]        day_number;
        logic signed [18:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } cal_result_t;

    localparam cal_result_t NO_RESULT = '0;

    // One row of the directed table. When has_want is set, the expected
    // result is the typed value rather than the predictor's.
    typedef struct packed {
        logic               cmd;
        logic [25:0]        day_number;
        logic signed [18:0] year;
        logic [3:0]         month;
        logic [5:0]         day;
        logic               has_want;
        cal_result_t        want;
    } cal_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    wire                busy;
    logic               i_command;
    logic [25:0]        i_day_number_in;
    logic signed [18:0] i_year_in;
    logic [3:0]         i_month_in;
    logic [5:0]         i_day_in;
    wire                o_done;
    wire [26:0]         o_day_number_out;
    wire signed [18:0]  o_year_out;
    wire [3:0]          o_month_out;
    wire [4:0]          o_day_out;

    // Expectation that travels with the item currently on the input ports.
    logic               drv_has_want;
    cal_result_t        drv_want;

    cal_result_t        pending_results[$];
    cal_row_t           directed[$];
    int                 error_count;
    int                 result_count;
    int                 cycle_count;

    julian_calendar_day_number_convert dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_day_number_in  (i_day_number_in),
        .i_year_in        (i_year_in),
        .i_month_in       (i_month_in),
        .i_day_in         (i_day_in),
        .o_done           (o_done),
        .o_day_number_out (o_day_number_out),
        .o_year_out       (o_year_out),
        .o_month_out      (o_month_out),
        .o_day_out        (o_day_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Calendar predictor. Day to date splits the serial number with the
    // four-year leap cycle and the five-month length cycle on a year that
    // starts in March, then shifts to a January year with no year zero.
    // Date to day is the inverse, after the range checks.
    function automatic cal_result_t predict_calendar(input logic cmd,
                                                     input logic [25:0] dn,
                                                     input logic signed [18:0] yr,
                                                     input logic [3:0] mo,
                                                     input logic [5:0] dy);
        cal_result_t res;
        longint      t;
        longint      y;
        longint      m;
        longint      d;
        longint      doy;
        longint      r;
        res = NO_RESULT;
        if (cmd == CMD_TO_DATE) begin
            if (dn != 0) begin
                t   = longint'(dn) * 4 + (L_EPOCH * 4 - 1);
                y   = t / L_4YEARS;
                doy = (t % L_4YEARS) / 4 + 1;
                t   = doy * 5 - 3;
                m   = t / L_5MONTHS;
                d   = (t % L_5MONTHS) / 5 + 1;
                if (m < 10) begin
                    m = m + 3;
                end else begin
                    y = y + 1;
                    m = m - 9;
                end
                y = y - L_BIAS;
                if (y <= 0) begin
                    y = y - 1;
                end
                res.year  = y[18:0];
                res.month = m[3:0];
                res.day   = d[4:0];
            end
        end else begin
            y = longint'(yr);
            m = longint'(mo);
            d = longint'(dy);
            if (y != 0 && y >= L_FIRST && m >= 1 && m <= 12 && d >= 1 && d <= 31
                    && !(y == L_FIRST && m == 1 && d == 1)) begin
                y = (y < 0) ? y + L_BIAS_BC : y + L_BIAS;
                if (m > 2) begin
                    m = m - 3;
                end else begin
                    m = m + 9;
                    y = y - 1;
                end
                r = (y * L_4YEARS) / 4 + (m * L_5MONTHS + 2) / 5 + d - L_EPOCH;
                if (r < 0) begin
                    r = 0;
                end
                res.day_number = r[26:0];
            end
        end
        return res;
    endfunction

    function automatic cal_row_t mk_row(input logic cmd, input logic [25:0] dn,
                                        input logic signed [18:0] yr, input logic [3:0] mo,
                                        input logic [5:0] dy, input logic has_want,
                                        input cal_result_t want);
        cal_row_t row;
        row.cmd        = cmd;
        row.day_number = dn;
        row.year       = yr;
        row.month      = mo;
        row.day        = dy;
        row.has_want   = has_want;
        row.want       = want;
        return row;
    endfunction

    // Every mismatch goes through here: one line each, with printing capped so
    // that a badly broken design cannot flood the log. All are still counted.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < PRINT_CAP) begin
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     result_count, what, got, want);
        end
        error_count++;
    endtask

    // Scoreboard. Inputs are driven at the falling edge, so at the rising edge
    // everything on the ports is stable: a transfer is start high with busy
    // low, and a result is o_done high. Expectations are queued at transfer
    // time and retired in order as results arrive.
    always @(posedge i_clk) begin
        cal_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end else if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0) begin
                if (drv_has_want) begin
                    pending_results.push_back(drv_want);
                end else begin
                    pending_results.push_back(predict_calendar(i_command, i_day_number_in,
                                                               i_year_in, i_month_in,
                                                               i_day_in));
                end
            end
            if (o_done !== 1'b0) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, day number", o_day_number_out, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_day_number_out !== want.day_number) begin
                        report_mismatch("day number", o_day_number_out, want.day_number);
                    end
                    if (o_year_out !== want.year) begin
                        report_mismatch("year", o_year_out, want.year);
                    end
                    if (o_month_out !== want.month) begin
                        report_mismatch("month", o_month_out, want.month);
                    end
                    if (o_day_out !== want.day) begin
                        report_mismatch("day", o_day_out, want.day);
                    end
                end
                result_count++;
            end
        end
    end

    // Presents one item after an idle gap of the given length and returns at
    // the falling edge that follows its transfer, with start still high so a
    // back-to-back item can follow without a bubble.
    task automatic send_item(input cal_row_t row, input int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command       = row.cmd;
        i_day_number_in = row.day_number;
        i_year_in       = row.year;
        i_month_in      = row.month;
        i_day_in        = row.day;
        drv_has_want    = row.has_want;
        drv_want        = row.want;
        start           = 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every queued result has come back.
    task automatic drain_results();
        start = 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        cal_row_t row;
        int       gap_max;
        int       pick;
        int       year_span;

        error_count     = 0;
        result_count    = 0;
        cycle_count     = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_command       = CMD_TO_DATE;
        i_day_number_in = '0;
        i_year_in       = '0;
        i_month_in      = '0;
        i_day_in        = '0;
        drv_has_want    = 1'b0;
        drv_want        = NO_RESULT;

        // Directed table. Typed expectations are the cases that can be read
        // straight off the calendar: day number zero, the first day, the
        // turn from 1 B.C. to A.D. 1, and every rejected date. The extremes,
        // the impossible date and the rest go through the predictor. The
        // unused fields carry junk to show that they are ignored.
        directed.push_back(mk_row(CMD_TO_DATE, 26'd0, 19'sd77, 4'd5, 6'd9, 1'b1, NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DATE, 26'd1, -19'sd1, 4'd15, 6'd63, 1'b1,
                                  cal_result_t'{27'd0, -19'sd4713, 4'd1, 5'd2}));
        directed.push_back(mk_row(CMD_TO_DATE, 26'd1721423, 19'sd0, 4'd0, 6'd0, 1'b1,
                                  cal_result_t'{27'd0, -19'sd1, 4'd12, 5'd31}));
        directed.push_back(mk_row(CMD_TO_DATE, 26'd1721424, 19'sd5, 4'd3, 6'd1, 1'b1,
                                  cal_result_t'{27'd0, 19'sd1, 4'd1, 5'd1}));
        directed.push_back(mk_row(CMD_TO_DATE, 26'h3FFFFFF, 19'sd0, 4'd0, 6'd0, 1'b0,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DATE, 26'h2000000, -19'sd262144, 4'd1, 6'd1, 1'b0,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DATE, 26'd2451545, 19'sd2000, 4'd1, 6'd1, 1'b0,
                                  NO_RESULT));
        // Rejected dates: year zero, years before the epoch, months and days
        // out of range, and the first of January of the epoch year.
        directed.push_back(mk_row(CMD_TO_DAY, 26'h3FFFFFF, 19'sd0, 4'd6, 6'd15, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd5, -19'sd4714, 4'd1, 6'd1, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, -19'sd262144, 4'd12, 6'd31, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd2000, 4'd0, 6'd10, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd2000, 4'd13, 6'd10, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd2000, 4'd15, 6'd10, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd2000, 4'd5, 6'd0, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd2000, 4'd5, 6'd32, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd2000, 4'd5, 6'd63, 1'b1,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, -19'sd4713, 4'd1, 6'd1, 1'b1,
                                  NO_RESULT));
        // Valid dates around the edges of the range.
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, -19'sd4713, 4'd1, 6'd2, 1'b1,
                                  cal_result_t'{27'd1, 19'sd0, 4'd0, 5'd0}));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, -19'sd1, 4'd12, 6'd31, 1'b1,
                                  cal_result_t'{27'd1721423, 19'sd0, 4'd0, 5'd0}));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd1, 4'd1, 6'd1, 1'b1,
                                  cal_result_t'{27'd1721424, 19'sd0, 4'd0, 5'd0}));
        directed.push_back(mk_row(CMD_TO_DAY, 26'h3FFFFFF, 19'sd262143, 4'd12, 6'd31, 1'b0,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, -19'sd4713, 4'd12, 6'd31, 1'b0,
                                  NO_RESULT));
        // An impossible date runs on into the next month.
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd2000, 4'd2, 6'd31, 1'b0,
                                  NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, -19'sd1, 4'd3, 6'd1, 1'b0, NO_RESULT));
        directed.push_back(mk_row(CMD_TO_DAY, 26'd0, 19'sd1582, 4'd10, 6'd4, 1'b0,
                                  NO_RESULT));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // First half of the table back to back, second half with random gaps.
        foreach (directed[k]) begin
            send_item(directed[k],
                      (k < directed.size() / 2) ? 0 : int'($urandom_range(0, 14)));
        end

        // Let the pipeline empty completely before the random phase starts.
        drain_results();

        // Random phase in bursts of fifty. Each burst either streams with no
        // idle cycles or draws a fresh gap for every item, so that gaps land
        // on every pipeline stage. Twice along the way the sender waits for
        // all outstanding results.
        gap_max = 14;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            end
            if (n == 250 || n == 500) begin
                drain_results();
            end
            row.cmd        = $urandom_range(0, 9) < 4 ? CMD_TO_DATE : CMD_TO_DAY;
            row.day_number = 26'($urandom);
            row.year       = 19'($urandom);
            row.month      = 4'($urandom);
            row.day        = 6'($urandom);
            row.has_want   = 1'b0;
            row.want       = NO_RESULT;
            pick = int'($urandom_range(0, 9));
            if (row.cmd == CMD_TO_DATE) begin
                // Mostly the full range, some near the epoch and a few of
                // the smallest numbers, zero among them.
                if (pick < 2) begin
                    row.day_number = 26'($urandom_range(0, 4000000));
                end else if (pick == 2) begin
                    row.day_number = 26'($urandom_range(0, 3));
                end
            end else if (pick < 8) begin
                // A well-formed date in the supported range of years.
                year_span      = 262143 - int'(L_FIRST);
                row.year       = 19'(int'($urandom_range(0, year_span)) + int'(L_FIRST));
                if (row.year == 19'sd0) begin
                    row.year = 19'sd1;
                end
                if (pick < 2) begin
                    row.year = 19'(int'($urandom_range(0, 6000)) + int'(L_FIRST));
                    if (row.year == 19'sd0) begin
                        row.year = -19'sd1;
                    end
                end
                row.month      = 4'($urandom_range(1, 12));
                row.day        = 6'($urandom_range(1, 31));
            end
            send_item(row, int'($urandom_range(0, gap_max)));
        end

        start = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // A few more cycles to catch any stray strobe from the pipeline.
        repeat (SETTLE) @(posedge i_clk);
        #1;
        if (pending_results.size() != 0) begin
            report_mismatch("results missing", 0, pending_results.size());
        end
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
